>>> hdl/life_pkg.sv
// ----------------------------------------------------------------------------
// life_pkg: shared definitions for the Life generation engine
// Register codes, handshake structs, window helpers and the B3/S23 rule.
// ----------------------------------------------------------------------------
package life_pkg;

  // Default frame limits
  localparam int unsigned MaxColsDefault = 32;
  localparam int unsigned MaxRowsDefault = 64;

  // Configuration register widths and reset values
  localparam int unsigned RowsCfgW  = 7;
  localparam int unsigned ColsCfgW  = 6;
  localparam int unsigned RowsReset = 20;
  localparam int unsigned ColsReset = 32;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 7;

  // Result queue sizing: up to two results are produced per cycle
  localparam int unsigned OutDepth = 4;
  localparam int unsigned EmitMax  = 2;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  // Life rule neighbor counts
  localparam logic [3:0] BirthCount   = 4'd3;
  localparam logic [3:0] SurviveCount = 4'd2;

  typedef enum logic [CfgIndexW-1:0] {
    CfgRowsInUse = 8'd0,
    CfgColsInUse = 8'd1
  } cfg_index_e;

  typedef struct packed {
    logic next_alive;
    logic frame_last;
  } result_t;

  // One cell position in flight between line store read and evaluation
  typedef struct packed {
    logic valid;
    logic flush;      // position of the trailing row sweep
    logic top_row;    // row 0: rows above count as dead
    logic first_col;
    logic last_col;
    logic frame_end;  // last position of the trailing sweep
    logic alive;
  } issue_t;

  // Results produced by the evaluator in one cycle
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t res_a;
    result_t res_b;
  } emit_t;

  // Shift a new column into the 3x3 window (bit 0 of each row is the right cell)
  function automatic logic [8:0] shift_window(logic [8:0] w, logic top, logic mid,
                                              logic bot);
    return {w[7:6], bot, w[4:3], mid, w[1:0], top};
  endfunction

  // B3/S23: count the eight neighbors around the center bit
  function automatic logic life_rule(logic [8:0] w);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        n = n + 4'(w[k]);
      end
    end
    return (n == BirthCount) || ((n == SurviveCount) && w[4]);
  endfunction

  // Last usable index for a count register: zero counts as one, clamp to limit
  function automatic int unsigned last_index(int unsigned value, int unsigned limit);
    if (value == 0) begin
      return 0;
    end
    if (value > limit) begin
      return limit - 1;
    end
    return value - 1;
  endfunction

endpackage

>>> hdl/life_if.sv
// ----------------------------------------------------------------------------
// life_if: handshake channels of the Life generation engine
// Cell input stream, result output stream and configuration write channel.
// ----------------------------------------------------------------------------
interface life_cell_in_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

interface life_cell_out_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic frame_last;

  modport source (output valid, output next_alive, output frame_last, input ready);
  modport sink (input valid, input next_alive, input frame_last, output ready);
endinterface

interface life_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [life_pkg::CfgIndexW-1:0]  index;
  logic [life_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/life_cellular_automaton_step_top.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_top: one Life (B3/S23) generation over a raster
// Line store RAM with read-modify-write, window evaluator and result queue.
// ----------------------------------------------------------------------------
// A cell's result is registered in the line store read and position stage, then in the result
// queue. Throughput: one cell per cycle while the queue has room; with the result side ready,
// input is held after a row end releases two results, and after the last cell of a frame
// while the final row is swept out of the single read port.
// Reset: position counters and queue cleared, rows_in_use 20, cols_in_use 32;
// the line store is not cleared, row 0 treats the rows above as dead.
module life_cellular_automaton_step_top #(
  parameter int unsigned MAX_COLS = life_pkg::MaxColsDefault,
  parameter int unsigned MAX_ROWS = life_pkg::MaxRowsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  life_cfg_if.sink        cfg_i,
  life_cell_in_if.sink    cell_i,
  life_cell_out_if.source cell_o
);

  localparam int unsigned ColW  = $clog2(MAX_COLS);
  localparam int unsigned RowW  = $clog2(MAX_ROWS);
  localparam int unsigned FillW = life_pkg::OutCntW + 1;
  localparam logic [ColW-1:0] LastColReset =
    ColW'(life_pkg::last_index(life_pkg::ColsReset, MAX_COLS));
  localparam logic [RowW-1:0] LastRowReset =
    RowW'(life_pkg::last_index(life_pkg::RowsReset, MAX_ROWS));

  logic [RowW-1:0]              row_q, row_d, last_row_q, last_row_d;
  logic [ColW-1:0]              col_q, col_d, last_col_q, last_col_d;
  logic [ColW-1:0]              fcol_q, fcol_d;
  logic                         flush_q, flush_d;
  life_pkg::issue_t             s1_q, s1_d;
  logic [ColW-1:0]              s1_addr_q;
  logic                         fwd_q, fwd_d;
  logic [1:0]                   fwd_data_q;
  life_pkg::emit_t              emit;
  logic [life_pkg::OutCntW-1:0] fifo_cnt;
  logic [FillW-1:0]             fill_sum;
  logic                         room, cfg_acc, in_acc, fl_issue, issue;
  logic                         at_last_col, at_last_row, fl_last;
  logic [ColW-1:0]              rd_addr;
  logic [1:0]                   rd_data, stored, wdata;
  logic                         top_g, mid_g, we;

  // Handshakes: hold input during the trailing sweep or when the queue is short
  always_comb begin
    fill_sum = FillW'(fifo_cnt) + FillW'(emit.push_a) + FillW'(emit.push_b);
    room     = (fill_sum <= FillW'(life_pkg::OutDepth - life_pkg::EmitMax));
  end

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign cell_i.ready = !flush_q && room;
  assign in_acc      = cell_i.valid && cell_i.ready;
  assign fl_issue    = flush_q && room;
  assign issue       = in_acc || fl_issue;
  assign at_last_col = (col_q == last_col_q);
  assign at_last_row = (row_q == last_row_q);
  assign fl_last     = (fcol_q == last_col_q);
  assign rd_addr     = flush_q ? fcol_q : col_q;

  // Advance raster position, sweep sequencer and configuration
  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    fcol_d     = fcol_q;
    flush_d    = flush_q;
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    if (cfg_acc) begin
      case (cfg_i.index)
        life_pkg::CfgRowsInUse: begin
          last_row_d = RowW'(life_pkg::last_index(
                         32'(cfg_i.data[life_pkg::RowsCfgW-1:0]), MAX_ROWS));
        end
        life_pkg::CfgColsInUse: begin
          last_col_d = ColW'(life_pkg::last_index(
                         32'(cfg_i.data[life_pkg::ColsCfgW-1:0]), MAX_COLS));
        end
        default: ;
      endcase
      if ((cfg_i.index == life_pkg::CfgRowsInUse) ||
          (cfg_i.index == life_pkg::CfgColsInUse)) begin
        row_d   = '0;
        col_d   = '0;
        flush_d = 1'b0;
      end
    end else if (in_acc) begin
      if (at_last_col) begin
        col_d = '0;
        if (at_last_row) begin
          row_d   = '0;
          flush_d = 1'b1;
          fcol_d  = '0;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (fl_issue) begin
      fcol_d = fcol_q + ColW'(1);
      if (fl_last) begin
        flush_d = 1'b0;
      end
    end
  end

  // Describe the position whose line store read is issued this cycle
  always_comb begin
    s1_d.valid     = issue;
    s1_d.flush     = fl_issue;
    s1_d.top_row   = !fl_issue && (row_q == '0);
    s1_d.first_col = (rd_addr == '0);
    s1_d.last_col  = fl_issue ? fl_last : at_last_col;
    s1_d.frame_end = fl_issue && fl_last;
    s1_d.alive     = !fl_issue && cell_i.cell_alive;
  end

  // Write back {older, newer} at the evaluated column; forward on same-entry read
  assign we    = s1_q.valid && !s1_q.flush;
  assign wdata = {mid_g, s1_q.alive};
  assign fwd_d = issue && we && (rd_addr == s1_addr_q);

  always_comb begin
    stored = fwd_q ? fwd_data_q : rd_data;
    top_g  = stored[1] && !s1_q.top_row;
    mid_g  = stored[0] && !s1_q.top_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      fcol_q     <= '0;
      flush_q    <= 1'b0;
      last_row_q <= LastRowReset;
      last_col_q <= LastColReset;
      s1_q       <= '0;
      fwd_q      <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      fcol_q     <= fcol_d;
      flush_q    <= flush_d;
      last_row_q <= last_row_d;
      last_col_q <= last_col_d;
      s1_q       <= s1_d;
      fwd_q      <= fwd_d;
    end
  end

  // Payload of the position in flight
  always_ff @(posedge clk_i) begin
    s1_addr_q  <= rd_addr;
    fwd_data_q <= wdata;
  end

  life_ram #(
    .Width (2),
    .Depth (MAX_COLS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr_q),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  life_cell_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1_q),
    .top_i  (top_g),
    .mid_i  (mid_g),
    .emit_o (emit)
  );

  life_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .count_o (fifo_cnt),
    .cell_o  (cell_o)
  );

  // Result queue never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= life_pkg::OutCntW'(life_pkg::OutDepth))
    else $error("result queue overflow");

  // The frame's last result is emitted only once the sweep has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.push_b && emit.res_b.frame_last) |-> !flush_q)
    else $error("frame end emitted while sweep still active");

  // Forwarded line store data belongs to a position in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_q.valid)
    else $error("forwarding without a position in flight");

endmodule

>>> hdl/life_ram.sv
// ----------------------------------------------------------------------------
// life_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module life_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/life_cell_engine.sv
// ----------------------------------------------------------------------------
// life_cell_engine: 3x3 window and rule evaluation
// Shifts one column per position into the window and emits up to two results.
// ----------------------------------------------------------------------------
module life_cell_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  life_pkg::issue_t s1_i,
  input  logic             top_i,
  input  logic             mid_i,
  output life_pkg::emit_t  emit_o
);

  logic [8:0] win_q;
  logic [8:0] win_d;
  logic [8:0] win_tail;

  // Shift in the new column, restarting from an empty window at column 0
  always_comb begin
    win_d    = life_pkg::shift_window(s1_i.first_col ? 9'd0 : win_q, top_i, mid_i,
                                      s1_i.alive);
    win_tail = life_pkg::shift_window(win_d, 1'b0, 1'b0, 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 9'd0;
    end else if (s1_i.valid) begin
      win_q <= win_d;
    end
  end

  // Emit the cell left of center, then the row's final cell at the last column
  always_comb begin
    emit_o.push_a           = s1_i.valid && !s1_i.top_row && !s1_i.first_col;
    emit_o.res_a.next_alive = life_pkg::life_rule(win_d);
    emit_o.res_a.frame_last = 1'b0;
    emit_o.push_b           = s1_i.valid && !s1_i.top_row && s1_i.last_col;
    emit_o.res_b.next_alive = life_pkg::life_rule(win_tail);
    emit_o.res_b.frame_last = s1_i.frame_end;
  end

endmodule

>>> hdl/life_out_fifo.sv
// ----------------------------------------------------------------------------
// life_out_fifo: result queue
// Takes up to two results per cycle, delivers one transaction per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module life_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  life_pkg::emit_t                emit_i,
  output logic [life_pkg::OutCntW-1:0]   count_o,
  life_cell_out_if.source                cell_o
);

  life_pkg::result_t                 mem_q [life_pkg::OutDepth];
  life_pkg::result_t                 first_res;
  logic [life_pkg::OutPtrW-1:0]      wr_ptr_q, wr_ptr_d, wr_next;
  logic [life_pkg::OutPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [life_pkg::OutCntW-1:0]      cnt_q, cnt_d;
  logic [1:0]                        n_push;
  logic                              pop;

  // Compact the pushes so the first one always lands at the write pointer
  always_comb begin
    first_res = emit_i.push_a ? emit_i.res_a : emit_i.res_b;
    n_push    = {1'b0, emit_i.push_a} + {1'b0, emit_i.push_b};
    wr_next   = wr_ptr_q + life_pkg::OutPtrW'(1);
    pop       = cell_o.valid && cell_o.ready;
    wr_ptr_d  = wr_ptr_q + life_pkg::OutPtrW'(n_push);
    rd_ptr_d  = rd_ptr_q + life_pkg::OutPtrW'(pop);
    cnt_d     = cnt_q + life_pkg::OutCntW'(n_push) - life_pkg::OutCntW'(pop);
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (emit_i.push_a || emit_i.push_b) begin
      mem_q[wr_ptr_q] <= first_res;
    end
    if (emit_i.push_a && emit_i.push_b) begin
      mem_q[wr_next] <= emit_i.res_b;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign cell_o.valid      = (cnt_q != '0);
  assign cell_o.next_alive = mem_q[rd_ptr_q].next_alive;
  assign cell_o.frame_last = mem_q[rd_ptr_q].frame_last;
  assign count_o           = cnt_q;

endmodule

>>> tb/life_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_step_checker: next-generation predictor and result scoreboard
// Watches the configuration, cell and result channels. Keeps its own line
// stores, 3x3 window and raster position, queues the cells each cell
// transaction releases, and compares every result transaction against the
// oldest queued cell.
// ----------------------------------------------------------------------------
module life_step_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  life_cfg_if         cfg_mon_i,
  life_cell_in_if     cell_mon_i,
  life_cell_out_if    result_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_awaited_o
);

  localparam int unsigned ColsCap = life_pkg::MaxColsDefault;
  localparam int unsigned RowsCap = life_pkg::MaxRowsDefault;
  localparam int unsigned RowsW   = life_pkg::RowsCfgW;
  localparam int unsigned ColsW   = life_pkg::ColsCfgW;

  // Model state: rows r-2 and r-1, window, position of the next cell
  logic [ColsCap-1:0]    two_up_row;
  logic [ColsCap-1:0]    one_up_row;
  logic [8:0]            nbhd;
  int unsigned           row_at;
  int unsigned           col_at;
  logic [RowsW-1:0]      rows_reg;
  logic [ColsW-1:0]      cols_reg;
  life_pkg::result_t     awaited_results_q[$];
  int unsigned           mismatches;

  assign mismatch_count_o = mismatches;

  // Zero counts as one, anything above the cap counts as the cap
  function automatic int unsigned usable(input int unsigned value, input int unsigned cap);
    if (value == 0) begin
      return 1;
    end
    if (value > cap) begin
      return cap;
    end
    return value;
  endfunction

  // Move every window row one step left and bring in the new right column
  function automatic logic [8:0] slide_column(input logic [8:0] w, input logic top,
                                              input logic mid, input logic bot);
    logic [2:0] top_row;
    logic [2:0] mid_row;
    logic [2:0] bot_row;
    top_row = {w[1:0], top};
    mid_row = {w[4:3], mid};
    bot_row = {w[7:6], bot};
    return {bot_row, mid_row, top_row};
  endfunction

  // B3/S23 on the center cell of a window
  function automatic logic next_state(input logic [8:0] w);
    int unsigned neighbors;
    neighbors = $countones(w) - w[4];
    return (neighbors == 3) || ((neighbors == 2) && w[4]);
  endfunction

  // Line store read with everything outside the frame dead
  function automatic logic row_bit(input logic [ColsCap-1:0] row, input int idx,
                                   input int unsigned width);
    if ((idx < 0) || (idx >= int'(width))) begin
      return 1'b0;
    end
    return row[idx];
  endfunction

  // Advance the model by one cell and queue the cells it releases
  task automatic predict_next_generation(input logic alive);
    int unsigned rows_eff;
    int unsigned cols_eff;
    int unsigned r;
    int unsigned c;
    int          k;
    logic        two_up;
    logic        one_up;
    logic [2:0]  top3;
    logic [2:0]  mid3;
    bit          last_col;
    bit          last_frame;
    rows_eff   = usable(32'(rows_reg), RowsCap);
    cols_eff   = usable(32'(cols_reg), ColsCap);
    r          = (row_at >= rows_eff) ? rows_eff - 1 : row_at;
    c          = (col_at >= cols_eff) ? cols_eff - 1 : col_at;
    last_col   = (c == cols_eff - 1);
    last_frame = last_col && (r == rows_eff - 1);

    // Read the column above, treat it as dead on the top row, shift stores down
    two_up        = (r == 0) ? 1'b0 : two_up_row[c];
    one_up        = (r == 0) ? 1'b0 : one_up_row[c];
    two_up_row[c] = one_up;
    one_up_row[c] = alive;
    nbhd          = slide_column((c == 0) ? 9'd0 : nbhd, two_up, one_up, alive);

    // Judge the cell one row up and one column left, plus the row end
    if (r >= 1) begin
      if (c >= 1) begin
        awaited_results_q.push_back(
          life_pkg::result_t'{next_alive: next_state(nbhd), frame_last: 1'b0});
      end
      if (last_col) begin
        awaited_results_q.push_back(life_pkg::result_t'{
          next_alive: next_state(slide_column(nbhd, 1'b0, 1'b0, 1'b0)), frame_last: 1'b0});
      end
    end

    // Flush the final row against a dead row below
    if (last_frame) begin
      for (k = 0; k < int'(cols_eff); k++) begin
        top3 = {row_bit(two_up_row, k - 1, cols_eff), row_bit(two_up_row, k, cols_eff),
                row_bit(two_up_row, k + 1, cols_eff)};
        mid3 = {row_bit(one_up_row, k - 1, cols_eff), row_bit(one_up_row, k, cols_eff),
                row_bit(one_up_row, k + 1, cols_eff)};
        awaited_results_q.push_back(life_pkg::result_t'{
          next_alive: next_state({3'b000, mid3, top3}),
          frame_last: (k == int'(cols_eff) - 1)});
      end
      row_at = 0;
      col_at = 0;
      nbhd   = '0;
    end else if (last_col) begin
      row_at = r + 1;
      col_at = 0;
    end else begin
      row_at = r;
      col_at = c + 1;
    end
  endtask

  // Compare results first, then apply writes and cells seen at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    life_pkg::result_t oldest;
    if (!rst_ni) begin
      two_up_row = '0;
      one_up_row = '0;
      nbhd       = '0;
      row_at     = 0;
      col_at     = 0;
      rows_reg   = RowsW'(life_pkg::RowsReset);
      cols_reg   = ColsW'(life_pkg::ColsReset);
      mismatches = 0;
      awaited_results_q.delete();
      results_awaited_o <= 0;
    end else begin
      if (result_mon_i.valid && result_mon_i.ready) begin
        if (awaited_results_q.size() == 0) begin
          $error("unexpected result transaction: next_alive %0b, frame_last %0b",
                 result_mon_i.next_alive, result_mon_i.frame_last);
          mismatches++;
        end else begin
          oldest = awaited_results_q.pop_front();
          if (result_mon_i.next_alive !== oldest.next_alive) begin
            $error("next_alive mismatch: expected %0b, actual %0b",
                   oldest.next_alive, result_mon_i.next_alive);
            mismatches++;
          end
          if (result_mon_i.frame_last !== oldest.frame_last) begin
            $error("frame_last mismatch: expected %0b, actual %0b",
                   oldest.frame_last, result_mon_i.frame_last);
            mismatches++;
          end
        end
      end

      // A known register write restarts the frame; other indexes are dropped
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        if ((cfg_mon_i.index == life_pkg::CfgRowsInUse) ||
            (cfg_mon_i.index == life_pkg::CfgColsInUse)) begin
          if (cfg_mon_i.index == life_pkg::CfgRowsInUse) begin
            rows_reg = cfg_mon_i.data[RowsW-1:0];
          end else begin
            cols_reg = cfg_mon_i.data[ColsW-1:0];
          end
          row_at = 0;
          col_at = 0;
          nbhd   = '0;
        end
      end

      if (cell_mon_i.valid && cell_mon_i.ready) begin
        predict_next_generation(cell_mon_i.cell_alive);
      end

      results_awaited_o <= awaited_results_q.size();
    end
  end

endmodule

>>> tb/life_cellular_automaton_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_top_tb: stimulus and verdict for the Life step
// Streams a directed set of frames, then random frames of many shapes, with
// random gaps on the cell channel and random stalls on the result channel.
// The frame shape is rewritten only while the engine is idle; the checker
// beside the engine predicts every result.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step_top_tb;

  localparam int unsigned RandomItems  = 230;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxGap       = 10;
  localparam int unsigned PartialCap   = 70;
  localparam int unsigned IdxW         = life_pkg::CfgIndexW;
  localparam int unsigned DataW        = life_pkg::CfgDataW;
  localparam int unsigned ColsW        = life_pkg::ColsCfgW;

  localparam logic [IdxW-1:0] FirstUnusedIndex = IdxW'(life_pkg::CfgColsInUse + 1);
  localparam logic [IdxW-1:0] LastIndex        = {IdxW{1'b1}};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          steady_source;
  bit          steady_sink;
  int unsigned idle_cycles;
  int unsigned random_cells;
  int unsigned mismatch_count;
  int unsigned results_awaited;

  life_cfg_if      cfg_ch ();
  life_cell_in_if  cell_in_ch ();
  life_cell_out_if cell_out_ch ();

  life_cellular_automaton_step_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .cell_i (cell_in_ch),
    .cell_o (cell_out_ch)
  );

  life_step_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_mon_i         (cfg_ch),
    .cell_mon_i        (cell_in_ch),
    .result_mon_i      (cell_out_ch),
    .mismatch_count_o  (mismatch_count),
    .results_awaited_o (results_awaited)
  );

  always #5 clk_i = ~clk_i;

  // Stop the run when no transaction of any kind moves for too long
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      idle_cycles <= 0;
    end else if ((cfg_ch.valid && cfg_ch.ready) || (cell_in_ch.valid && cell_in_ch.ready) ||
                 (cell_out_ch.valid && cell_out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin
    int unsigned stall;
    cell_out_ch.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      stall = steady_sink ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        cell_out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cell_out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!cell_out_ch.valid);
    end
  end

  function automatic int unsigned usable_count(input int unsigned value,
                                               input int unsigned cap);
    if (value == 0) begin
      return 1;
    end
    if (value > cap) begin
      return cap;
    end
    return value;
  endfunction

  // Offer one cell after a random gap and hold it until accepted
  task automatic send_cell(input logic alive);
    int unsigned gap;
    gap = steady_source ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      cell_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_in_ch.valid      <= 1'b1;
    cell_in_ch.cell_alive <= alive;
    do @(posedge clk_i); while (!cell_in_ch.ready);
  endtask

  // Hold the register write until accepted; the caller drops valid afterwards
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Drop the cell valid, wait out every predicted result, then the pipeline
  task automatic settle();
    cell_in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_awaited != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One random phase: set the shape, stream whole or broken frames, drain
  task automatic run_phase(input logic [DataW-1:0] rows_data,
                           input logic [DataW-1:0] cols_data, input bit whole_frame);
    int unsigned frame_cells;
    int unsigned count;
    int unsigned pause_at;
    int unsigned density;
    int unsigned i;
    frame_cells   = usable_count(32'(rows_data), life_pkg::MaxRowsDefault) *
                    usable_count(32'(cols_data[ColsW-1:0]), life_pkg::MaxColsDefault);
    steady_source = ($urandom_range(0, 3) == 0);
    steady_sink   = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(life_pkg::CfgRowsInUse, rows_data);
      write_reg(life_pkg::CfgColsInUse, cols_data);
    end else begin
      write_reg(life_pkg::CfgColsInUse, cols_data);
      write_reg(life_pkg::CfgRowsInUse, rows_data);
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(IdxW'($urandom_range(FirstUnusedIndex, LastIndex)), DataW'($urandom));
    end
    cfg_ch.valid <= 1'b0;

    if (whole_frame) begin
      count = frame_cells;
    end else if (frame_cells > PartialCap) begin
      count = $urandom_range(1, PartialCap);
    end else if ($urandom_range(0, 4) == 0) begin
      count = $urandom_range(1, frame_cells);
    end else begin
      count = frame_cells * $urandom_range(1, 2);
    end
    pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, count) : count;
    density  = $urandom_range(15, 60);

    for (i = 0; i < count; i++) begin
      // Hold off mid-stream until the engine is empty, maybe poke an unused index
      if (i == pause_at) begin
        settle();
        if ($urandom_range(0, 1) == 1) begin
          write_reg(IdxW'($urandom_range(FirstUnusedIndex, LastIndex)),
                    DataW'($urandom));
        end
        cfg_ch.valid <= 1'b0;
      end
      send_cell($urandom_range(0, 99) < density);
    end
    settle();
    random_cells += count;
  endtask

  initial begin
    logic [DataW-1:0] rows_data;
    logic [DataW-1:0] cols_data;
    int unsigned      i;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    cell_in_ch.valid      <= 1'b0;
    cell_in_ch.cell_alive <= 1'b0;
    steady_source         = 1'b0;
    steady_sink           = 1'b0;
    random_cells          = 0;
    rst_ni                <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset shape: top-row cells release nothing
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b1);
    settle();

    // Vertical blinker on a 3x3 frame
    write_reg(life_pkg::CfgRowsInUse, 7'd3);
    write_reg(life_pkg::CfgColsInUse, 7'd3);
    cfg_ch.valid <= 1'b0;
    for (i = 0; i < 9; i++) begin
      send_cell((i % 3) == 1);
    end
    settle();

    // Zero counts as one: a single-cell frame
    write_reg(life_pkg::CfgRowsInUse, '0);
    write_reg(life_pkg::CfgColsInUse, '0);
    cfg_ch.valid <= 1'b0;
    send_cell(1'b1);
    settle();

    // Full 2x4 block, with writes to unused indexes between its rows
    write_reg(life_pkg::CfgRowsInUse, 7'd2);
    write_reg(life_pkg::CfgColsInUse, 7'd4);
    cfg_ch.valid <= 1'b0;
    repeat (4) send_cell(1'b1);
    settle();
    write_reg(LastIndex, '1);
    write_reg(FirstUnusedIndex, '0);
    cfg_ch.valid <= 1'b0;
    repeat (4) send_cell(1'b1);
    settle();

    // Clamped shapes at the limits: tallest single column, widest two rows
    run_phase(7'd127, 7'd0, 1'b1);
    run_phase(7'd2, 7'd63, 1'b1);

    // Random shapes, mostly small, now and then at the extremes
    while (random_cells < RandomItems) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       rows_data = 7'd0;
          1:       rows_data = 7'd64;
          2:       rows_data = 7'd127;
          default: rows_data = DataW'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 3))
          0:       cols_data = 7'd0;
          1:       cols_data = 7'd32;
          2:       cols_data = 7'd127;
          default: cols_data = DataW'($urandom_range(0, 127));
        endcase
      end else begin
        rows_data = DataW'($urandom_range(1, 6));
        cols_data = DataW'($urandom_range(1, 8));
      end
      run_phase(rows_data, cols_data, 1'b0);
    end

    // The last phase has already drained the engine
    if ((mismatch_count == 0) && (results_awaited == 0)) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
